// File: hw/rtl/lpfd_pkg.sv
// Shared constants and types for the length-prefixed frame deframer.
// No dependencies; imported by the deframer top level.
package lpfd_pkg;

  localparam int HDR_BYTES = 16;
  localparam int HDR_CNT_W = $clog2(HDR_BYTES);

  typedef logic [1:0] status_t;

  localparam status_t ST_MORE = 2'd0;
  localparam status_t ST_DONE = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  // configuration register indexes (byte address = 4 * index)
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;

  // header byte positions
  localparam logic [HDR_CNT_W-1:0] POS_VER0 = HDR_CNT_W'(4);
  localparam logic [HDR_CNT_W-1:0] POS_TYP0 = HDR_CNT_W'(6);
  localparam logic [HDR_CNT_W-1:0] POS_SEQ0 = HDR_CNT_W'(8);
  localparam logic [HDR_CNT_W-1:0] POS_LEN0 = HDR_CNT_W'(12);
  localparam logic [HDR_CNT_W-1:0] POS_LAST = HDR_CNT_W'(HDR_BYTES - 1);

endpackage

// File: hw/rtl/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer: top level, single module.
// Depends on lpfd_pkg (constants, status codes, types).
//
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) carries the received
//   byte stream, one word per accepted cycle. Every accepted word yields
//   exactly one result word on the output channel (out_valid / out_stall),
//   which passes the byte through and tags it: header or payload, status
//   (more, complete, corrupt), last-of-frame, and the decoded header fields.
//   Frames are a 16-byte little-endian header (magic, version, type,
//   sequence, payload length) followed by the payload. On the last header
//   byte the magic and length are checked against the configuration
//   registers; a mismatch reports corrupt and the next byte opens a new
//   header. A zero-length frame completes on its last header byte.
//   The result register is loaded at the edge that accepts the byte.
//   Throughput is one byte per cycle while the receiver does not stall,
//   set by the single pass of header assembly, check and payload countdown
//   ahead of that register. When the receiver stalls with a result waiting,
//   in_stall rises in the same cycle and both sides hold.
//   Reset (rst_n low, synchronous) returns to header collection, empties
//   the result register and loads the register defaults (magic 0, max
//   length 16777216). Configuration goes through an APB-style port at
//   byte addresses 0 (magic) and 4 (max length); pready is always high.
module length_prefixed_frame_deframer
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_out,
  output logic        out_in_header,
  output logic [1:0]  out_frame_status,
  output logic        out_frame_last,
  output logic [15:0] out_msg_version,
  output logic [15:0] out_msg_type,
  output logic [31:0] out_msg_sequence,
  output logic [31:0] out_msg_length,
  output logic [32:0] out_frame_bytes,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------------------------------------------------------- config
  logic [31:0] magic_cfg_r;
  logic [31:0] max_len_cfg_r;
  logic        cfg_wr;
  logic        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // word-aligned decode: bit 2 selects the register
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_prdata = (cfg_idx == REG_MAGIC) ? magic_cfg_r : max_len_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_cfg_r   <= '0;
      max_len_cfg_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_MAGIC) begin
        magic_cfg_r <= cfg_pwdata;
      end else begin
        max_len_cfg_r <= cfg_pwdata;
      end
    end
  end

  // ------------------------------------------------------------- handshake
  logic out_valid_r;
  logic accept;

  // hold the input whenever a result is waiting and the receiver stalls
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // ----------------------------------------------------------- frame state
  logic [HDR_CNT_W-1:0] hdr_cnt_r,   hdr_cnt_nxt;
  logic [31:0]          magic_r,     magic_nxt;
  logic [15:0]          version_r,   version_nxt;
  logic [15:0]          type_r,      type_nxt;
  logic [31:0]          sequence_r,  sequence_nxt;
  logic [31:0]          length_r,    length_nxt;
  logic [31:0]          remain_r,    remain_nxt;
  logic                 payload_r,   payload_nxt;

  // result word next values
  logic        res_in_header;
  status_t     res_status;
  logic        res_last;
  logic        res_fields;   // decoded header fields shown
  logic        res_size;     // frame size shown
  logic [32:0] frame_total;

  assign frame_total = 33'(HDR_BYTES) + {1'b0, length_nxt};

  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    magic_nxt     = magic_r;
    version_nxt   = version_r;
    type_nxt      = type_r;
    sequence_nxt  = sequence_r;
    length_nxt    = length_r;
    remain_nxt    = remain_r;
    payload_nxt   = payload_r;
    res_in_header = 1'b1;
    res_status    = ST_MORE;
    res_last      = 1'b0;
    res_fields    = 1'b0;
    res_size      = 1'b0;

    if (payload_r) begin
      // count down the payload; the byte that brings the count to zero ends it
      res_in_header = 1'b0;
      res_fields    = 1'b1;
      res_size      = 1'b1;
      if (remain_r != '0) begin
        remain_nxt = remain_r - 32'd1;
      end
      if (remain_nxt == '0) begin
        res_status  = ST_DONE;
        res_last    = 1'b1;
        payload_nxt = 1'b0;
        hdr_cnt_nxt = '0;
      end
    end else begin
      // drop the byte into its header field, little-endian
      case (hdr_cnt_r[3:2])
        2'd0: magic_nxt[8*hdr_cnt_r[1:0] +: 8] = in_data_byte;
        2'd1: begin
          if (hdr_cnt_r < POS_TYP0) begin
            version_nxt[8*hdr_cnt_r[0] +: 8] = in_data_byte;
          end else begin
            type_nxt[8*hdr_cnt_r[0] +: 8] = in_data_byte;
          end
        end
        2'd2: sequence_nxt[8*hdr_cnt_r[1:0] +: 8] = in_data_byte;
        default: length_nxt[8*hdr_cnt_r[1:0] +: 8] = in_data_byte;
      endcase

      if (hdr_cnt_r != POS_LAST) begin
        hdr_cnt_nxt = hdr_cnt_r + HDR_CNT_W'(1);
      end else begin
        hdr_cnt_nxt = '0;
        res_fields  = 1'b1;
        if (magic_nxt != magic_cfg_r || length_nxt > max_len_cfg_r) begin
          res_status = ST_BAD;
        end else begin
          res_size = 1'b1;
          if (length_nxt == '0) begin
            res_status = ST_DONE;
            res_last   = 1'b1;
          end else begin
            remain_nxt  = length_nxt;
            payload_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r  <= '0;
      magic_r    <= '0;
      version_r  <= '0;
      type_r     <= '0;
      sequence_r <= '0;
      length_r   <= '0;
      remain_r   <= '0;
      payload_r  <= 1'b0;
    end else if (accept) begin
      hdr_cnt_r  <= hdr_cnt_nxt;
      magic_r    <= magic_nxt;
      version_r  <= version_nxt;
      type_r     <= type_nxt;
      sequence_r <= sequence_nxt;
      length_r   <= length_nxt;
      remain_r   <= remain_nxt;
      payload_r  <= payload_nxt;
    end
  end

  // --------------------------------------------------------- result word
  logic [7:0]  byte_r;
  logic        in_header_r;
  status_t     status_r;
  logic        last_r;
  logic [15:0] version_o_r;
  logic [15:0] type_o_r;
  logic [31:0] sequence_o_r;
  logic [31:0] length_o_r;
  logic [32:0] frame_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload of the result word: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r        <= in_data_byte;
      in_header_r   <= res_in_header;
      status_r      <= res_status;
      last_r        <= res_last;
      version_o_r   <= res_fields ? version_nxt  : '0;
      type_o_r      <= res_fields ? type_nxt     : '0;
      sequence_o_r  <= res_fields ? sequence_nxt : '0;
      length_o_r    <= res_fields ? length_nxt   : '0;
      frame_bytes_r <= res_size   ? frame_total  : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = byte_r;
  assign out_in_header    = in_header_r;
  assign out_frame_status = status_r;
  assign out_frame_last   = last_r;
  assign out_msg_version  = version_o_r;
  assign out_msg_type     = type_o_r;
  assign out_msg_sequence = sequence_o_r;
  assign out_msg_length   = length_o_r;
  assign out_frame_bytes  = frame_bytes_r;

  // ------------------------------------------------------------ assertions
  // payload counting only ever starts from a fresh header count
  a_payload_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    payload_r |-> (hdr_cnt_r == '0))
    else $error("header count not cleared during payload");

  // a payload in progress always has bytes left to come
  a_payload_remain: assert property (@(posedge clk) disable iff (!rst_n)
    payload_r |-> (remain_r != '0))
    else $error("payload phase with zero remaining");

  // the final payload byte leaves the payload phase
  a_payload_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && payload_r && remain_r == 32'd1) |=> !payload_r)
    else $error("payload phase not left after final byte");

  // last-of-frame marks only complete frames
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (status_r == ST_DONE))
    else $error("frame_last without complete status");

  // a corrupt report is a header byte and carries no frame size
  a_bad_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_BAD) |-> (in_header_r && frame_bytes_r == '0))
    else $error("corrupt report on payload byte or with size");

endmodule
